>>> src/dep_pkg.sv
// ----------------------------------------------------------------------------
// dep_pkg
// shared constants, types and the parent-slot function of the interval-heap priority queue
// ----------------------------------------------------------------------------
`default_nettype none
package dep_pkg;
  localparam int unsigned Capacity = 1024;
  localparam int unsigned KeyWidth = 32;
  localparam int unsigned AddrWidth = $clog2(Capacity + 1);
  localparam int unsigned CountWidth = 11;

  localparam logic [1:0] OpPush = 2'd0;
  localparam logic [1:0] OpPopMin = 2'd1;
  localparam logic [1:0] OpPopMax = 2'd2;

  localparam logic [1:0] StDone = 2'd0;
  localparam logic [1:0] StEmpty = 2'd1;
  localparam logic [1:0] StFull = 2'd2;

  typedef logic [AddrWidth-1:0] slot_t;
  typedef logic signed [KeyWidth-1:0] key_t;

  // parent slot in the interval heap
  function automatic slot_t up_slot(slot_t v);
    if (v[1:0] == 2'd3 || v[1:0] == 2'd0) begin
      up_slot = v >> 1;
    end else begin
      up_slot = (v >> 1) - slot_t'(1);
    end
  endfunction
endpackage
`default_nettype wire

>>> src/double_ended_priority_queue_core.sv
// ----------------------------------------------------------------------------
// double_ended_priority_queue_core
// interval heap of signed keys in one memory, with min/max/count report
// push writes the new last slot, then compares and swaps with its mate and climbs;
// into an empty queue it goes straight to the report; pop moves the last key into the
// popped slot, sifts it down level by level, then stops or does the mate check and climbs
// one request at a time; the report waits while the previous one is unread
// reset clears the count and the control state; the key memory is not cleared
// ----------------------------------------------------------------------------
`default_nettype none
module double_ended_priority_queue_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  opcode_i,
  input  wire logic signed [31:0] key_in_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic signed [31:0] min_key_o,
  output logic signed [31:0] max_key_o,
  output logic [10:0]      entry_count_o,
  output logic [1:0]       status_o
);
  localparam logic [3:0] SIdle = 4'd0, SRdA = 4'd1, SRdB = 4'd2, SCmp = 4'd3,
                         SWrB = 4'd4, SRdL = 4'd5, SRdR = 4'd6, SRdV = 4'd7,
                         SDnC = 4'd8, SDnW = 4'd9, SRep1 = 4'd10, SRep2 = 4'd11,
                         SRep3 = 4'd12, SOut = 4'd13, SPopW = 4'd14;
  // up-mode codes for the shared compare/swap pass
  localparam logic [1:0] MPart = 2'd0, MUp = 2'd1, MFin = 2'd2;

  logic [3:0] st_q;
  logic [1:0] mode_q;
  logic [dep_pkg::CountWidth-1:0] cnt_q;
  dep_pkg::slot_t v_q, b_q, l_q, r_q;
  dep_pkg::key_t ka_q, kb_q, kl_q, kr_q, min_q;
  logic [1:0] sts_q;
  logic popdn_q;
  logic rd_pending_q;

  logic we;
  dep_pkg::slot_t waddr, raddr;
  dep_pkg::key_t wdata, rdata;

  dep_ram u_ram (.clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
                 .raddr_i(raddr), .rdata_o(rdata));

  dep_pkg::slot_t cnt_s, lc, rc, partner;
  assign cnt_s = dep_pkg::slot_t'(cnt_q);
  assign lc = v_q[0] ? (v_q << 1) + dep_pkg::slot_t'(1) : (v_q << 1);
  assign rc = v_q[0] ? (v_q << 1) + dep_pkg::slot_t'(3) : (v_q << 1) + dep_pkg::slot_t'(2);
  always_comb begin
    if (v_q[0]) begin
      partner = (v_q + dep_pkg::slot_t'(1) <= cnt_s) ? v_q + dep_pkg::slot_t'(1)
                : dep_pkg::up_slot(v_q + dep_pkg::slot_t'(1));
    end else begin
      partner = v_q - dep_pkg::slot_t'(1);
    end
  end

  // swap decision: a at v_q, b at b_q
  logic go;
  always_comb begin
    if (mode_q == MUp) begin
      go = v_q[0] ? (ka_q < kb_q) : (kb_q < ka_q);
    end else begin
      go = b_q[0] ? (ka_q < kb_q) : (kb_q < ka_q);
    end
  end

  dep_pkg::slot_t pick;
  dep_pkg::key_t kp;
  logic dn_go;
  always_comb begin
    if (v_q[0]) begin
      pick = (kr_q < kl_q) ? r_q : l_q;
      kp = (kr_q < kl_q) ? kr_q : kl_q;
      dn_go = kp < ka_q;
    end else begin
      pick = (kl_q < kr_q) ? r_q : l_q;
      kp = (kl_q < kr_q) ? kr_q : kl_q;
      dn_go = ka_q < kp;
    end
  end

  always_comb begin
    we = 1'b0;
    waddr = v_q;
    wdata = ka_q;
    raddr = v_q;
    case (st_q)
      SIdle: begin
        if (in_valid_i && opcode_i == dep_pkg::OpPush && cnt_q < dep_pkg::Capacity) begin
          we = 1'b1;
          waddr = cnt_s + dep_pkg::slot_t'(1);
          wdata = key_in_i;
        end
        raddr = (opcode_i == dep_pkg::OpPopMin || cnt_q < 2) ? dep_pkg::slot_t'(1)
                : dep_pkg::slot_t'(2);
        if (opcode_i == dep_pkg::OpPopMin || opcode_i == dep_pkg::OpPopMax) begin
          raddr = cnt_s;
        end
      end
      SRdA: raddr = v_q;
      SRdB: raddr = b_q;
      SCmp: begin
        if (go && !rd_pending_q) begin
          we = 1'b1;
          waddr = v_q;
          wdata = kb_q;
        end
      end
      SWrB: begin
        we = 1'b1;
        waddr = b_q;
        wdata = ka_q;
      end
      SPopW: begin
        we = !rd_pending_q;
        waddr = v_q;
        wdata = ka_q;
      end
      SRdL: raddr = l_q;
      SRdR: raddr = r_q;
      SRdV: raddr = v_q;
      SDnW: begin
        we = 1'b1;
        waddr = pick;
        wdata = ka_q;
      end
      SDnC: begin
        if (dn_go && !popdn_q) begin
          we = 1'b1;
          waddr = v_q;
          wdata = kp;
        end
      end
      SRep1: raddr = dep_pkg::slot_t'(1);
      SRep2, SOut: raddr = (cnt_q < 2) ? dep_pkg::slot_t'(1) : dep_pkg::slot_t'(2);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle;
      cnt_q <= '0;
      out_valid_o <= 1'b0;
      sts_q <= dep_pkg::StDone;
      mode_q <= MPart;
      popdn_q <= 1'b0;
      rd_pending_q <= 1'b0;
    end else begin
      case (st_q)
        SIdle: begin
          if (in_valid_i) begin
            if (opcode_i == dep_pkg::OpPush) begin
              if (cnt_q >= dep_pkg::Capacity) begin
                sts_q <= dep_pkg::StFull;
                st_q <= SRep1;
              end else begin
                sts_q <= dep_pkg::StDone;
                cnt_q <= cnt_q + 1'b1;
                v_q <= cnt_s + dep_pkg::slot_t'(1);
                mode_q <= MPart;
                st_q <= (cnt_q == 0) ? SRep1 : SRdA;
              end
            end else if (opcode_i == dep_pkg::OpPopMin || opcode_i == dep_pkg::OpPopMax) begin
              if (cnt_q == 0) begin
                sts_q <= dep_pkg::StEmpty;
                st_q <= SRep1;
              end else begin
                sts_q <= dep_pkg::StDone;
                // move last key into the popped slot (slot 1 for pop-min or a single entry, else slot 2)
                v_q <= (opcode_i == dep_pkg::OpPopMin || cnt_q < 2) ? dep_pkg::slot_t'(1)
                       : dep_pkg::slot_t'(2);
                cnt_q <= cnt_q - 1'b1;
                st_q <= SPopW;
                rd_pending_q <= 1'b1;
              end
            end else begin
              sts_q <= dep_pkg::StDone;
              st_q <= SRep1;
            end
          end
        end
        SPopW: begin
          // rdata holds last key; write it into target slot
          if (rd_pending_q) begin
            ka_q <= rdata;
            rd_pending_q <= 1'b0;
          end else if (cnt_q <= 1) begin
            st_q <= SRep1;
          end else begin
            l_q <= lc;
            r_q <= (rc > cnt_s) ? lc : rc;
            st_q <= (lc > cnt_s) ? SRdB : SRdL;
            b_q <= partner;
            mode_q <= MFin;
          end
        end
        SRdA: begin
          b_q <= (mode_q == MUp) ? dep_pkg::up_slot(v_q) : partner;
          st_q <= SRdB;
        end
        SRdB: begin
          if (mode_q == MPart) begin
            ka_q <= rdata;
          end
          st_q <= SCmp;
          rd_pending_q <= 1'b1;
        end
        SCmp: begin
          if (rd_pending_q) begin
            kb_q <= rdata;
            rd_pending_q <= 1'b0;
          end else if (go) begin
            st_q <= SWrB;
          end else if (mode_q == MPart && v_q > dep_pkg::slot_t'(2)) begin
            mode_q <= MUp;
            b_q <= dep_pkg::up_slot(v_q);
            st_q <= SRdB;
          end else begin
            st_q <= SRep1;
          end
        end
        SWrB: begin
          v_q <= b_q;
          mode_q <= MUp;
          b_q <= dep_pkg::up_slot(b_q);
          if (b_q > dep_pkg::slot_t'(2)) begin
            st_q <= SRdB;
          end else begin
            st_q <= SRep1;
          end
        end
        SRdL: st_q <= SRdR;
        SRdR: begin
          kl_q <= rdata;
          st_q <= SRdV;
        end
        SRdV: begin
          kr_q <= rdata;
          st_q <= SDnC;
          popdn_q <= 1'b1;
        end
        SDnC: begin
          if (popdn_q) begin
            ka_q <= rdata;
            popdn_q <= 1'b0;
          end else if (dn_go) begin
            st_q <= SDnW;
          end else begin
            b_q <= partner;
            mode_q <= MFin;
            st_q <= (lc > cnt_s) ? SRdB : SRep1;
          end
        end
        SDnW: begin
          v_q <= pick;
          st_q <= SRep3;
        end
        SRep3: begin
          l_q <= lc;
          r_q <= (rc > cnt_s) ? lc : rc;
          b_q <= partner;
          mode_q <= MFin;
          st_q <= (lc > cnt_s) ? SRdB : SRdL;
        end
        SRep1: st_q <= SRep2;
        SRep2: begin
          min_q <= rdata;
          st_q <= SOut;
        end
        SOut: begin
          if (!out_valid_o) begin
            max_key_o <= (cnt_q == 0) ? '0 : rdata;
            min_key_o <= (cnt_q == 0) ? '0 : min_q;
            entry_count_o <= cnt_q;
            status_o <= sts_q;
            out_valid_o <= 1'b1;
            st_q <= SIdle;
          end
        end
        default: st_q <= SIdle;
      endcase
      if (out_valid_o && out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  assign in_ready_o = (st_q == SIdle);

  // the entry count never rises above the capacity
  property p_count_bound;
    @(posedge clk_i) disable iff (!rst_ni) cnt_q <= dep_pkg::Capacity;
  endproperty
  a_count_bound: assert property (p_count_bound) else $error("count above capacity");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != SIdle) |-> !in_ready_o) else $error("ready while busy");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && entry_count_o == 0) |-> (min_key_o == 0 && max_key_o == 0))
    else $error("empty queue reports keys");

  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && entry_count_o != 0) |-> (min_key_o <= max_key_o))
    else $error("min above max");
endmodule
`default_nettype wire

>>> src/dep_ram.sv
// ----------------------------------------------------------------------------
// dep_ram
// key memory, one write port and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none
module dep_ram (
  input  wire logic           clk_i,
  input  wire logic           we_i,
  input  wire dep_pkg::slot_t waddr_i,
  input  wire dep_pkg::key_t  wdata_i,
  input  wire dep_pkg::slot_t raddr_i,
  output dep_pkg::key_t       rdata_o
);
  dep_pkg::key_t mem_q [0:dep_pkg::Capacity];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the interval-heap double-ended priority queue:
// a directed table walks empty, extreme, equal-key and unused-opcode cases,
// then random push/pop traffic fills the queue to capacity and works it down,
// with every report checked against its table entry or an in-bench interval-heap predictor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb;
  localparam logic [1:0] OpNone = 2'd3;
  localparam int unsigned CycleLimit = 2000000;
  localparam int unsigned DrainCycles = 200;

  typedef struct packed {
    dep_pkg::key_t min_key;
    dep_pkg::key_t max_key;
    logic [10:0]   entry_count;
    logic [1:0]    status;
  } report_t;

  typedef struct {
    logic [1:0]    op;
    dep_pkg::key_t key;
    bit            typed;
    report_t       want;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] opcode_i = OpNone;
  dep_pkg::key_t key_in_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  dep_pkg::key_t min_key_o;
  dep_pkg::key_t max_key_o;
  logic [10:0] entry_count_o;
  logic [1:0] status_o;

  double_ended_priority_queue_core DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  dep_pkg::key_t heap_keys [1:dep_pkg::Capacity];
  int unsigned heap_size = 0;

  report_t report_q[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned sender_idle_pct = 0;
  int unsigned receiver_idle_pct = 0;
  int unsigned requests = 0;
  int unsigned full_refusals = 0;
  int unsigned empty_refusals = 0;

  function automatic dep_pkg::key_t slot_key(int unsigned s);
    return (s >= 1 && s <= dep_pkg::Capacity) ? heap_keys[s] : dep_pkg::key_t'(0);
  endfunction

  function automatic void swap_slots(int unsigned a, int unsigned b);
    dep_pkg::key_t t;
    if (a < 1 || a > dep_pkg::Capacity || b < 1 || b > dep_pkg::Capacity) return;
    t = heap_keys[a];
    heap_keys[a] = heap_keys[b];
    heap_keys[b] = t;
  endfunction

  function automatic int unsigned parent_of(int unsigned v);
    if (v % 4 == 3 || v % 4 == 0) return v / 2;
    return v / 2 - 1;
  endfunction

  function automatic int unsigned mate_of(int unsigned v);
    if (v % 2 == 1) return (v + 1 <= heap_size) ? v + 1 : parent_of(v + 1);
    return v - 1;
  endfunction

  function automatic bit out_of_order(int unsigned a, int unsigned b);
    int unsigned lo;
    int unsigned hi;
    lo = (b % 2 == 1) ? b : a;
    hi = (b % 2 == 1) ? a : b;
    return slot_key(hi) < slot_key(lo);
  endfunction

  function automatic void bubble_up(int unsigned v);
    int unsigned p;
    bit go;
    while (v > 2) begin
      p = parent_of(v);
      go = (v % 2 == 1) ? (slot_key(v) < slot_key(p)) : (slot_key(p) < slot_key(v));
      if (!go) break;
      swap_slots(v, p);
      v = p;
    end
  endfunction

  function automatic int unsigned bubble_down(int unsigned v);
    int unsigned l;
    int unsigned r;
    int unsigned pick;
    forever begin
      l = (v % 2 == 1) ? 2 * v + 1 : 2 * v;
      r = (v % 2 == 1) ? 2 * v + 3 : 2 * v + 2;
      if (l > heap_size) return v;
      if (r > heap_size) r = l;
      if (v % 2 == 1) begin
        pick = (slot_key(r) < slot_key(l)) ? r : l;
        if (!(slot_key(pick) < slot_key(v))) return v;
      end else begin
        pick = (slot_key(l) < slot_key(r)) ? r : l;
        if (!(slot_key(v) < slot_key(pick))) return v;
      end
      swap_slots(v, pick);
      v = pick;
    end
  endfunction

  function automatic void insert_key(dep_pkg::key_t k);
    int unsigned v;
    int unsigned m;
    heap_size++;
    v = heap_size;
    heap_keys[v] = k;
    if (v == 1) return;
    m = mate_of(v);
    if (out_of_order(v, m)) begin
      swap_slots(v, m);
      v = m;
    end
    bubble_up(v);
  endfunction

  function automatic void remove_slot(int unsigned v);
    int unsigned m;
    swap_slots(heap_size, v);
    heap_size--;
    if (heap_size <= 1) return;
    v = bubble_down(v);
    if (((v % 2 == 1) ? 2 * v + 1 : 2 * v) > heap_size) begin
      m = mate_of(v);
      if (out_of_order(v, m)) begin
        swap_slots(v, m);
        bubble_up(m);
      end
    end
  endfunction

  function automatic report_t apply_request(logic [1:0] op, dep_pkg::key_t k);
    report_t r;
    r.status = dep_pkg::StDone;
    if (op == dep_pkg::OpPush) begin
      if (heap_size >= dep_pkg::Capacity) r.status = dep_pkg::StFull;
      else insert_key(k);
    end else if (op == dep_pkg::OpPopMin || op == dep_pkg::OpPopMax) begin
      if (heap_size == 0) r.status = dep_pkg::StEmpty;
      else if (op == dep_pkg::OpPopMin) remove_slot(1);
      else remove_slot(heap_size < 2 ? heap_size : 2);
    end
    r.min_key = (heap_size == 0) ? dep_pkg::key_t'(0) : slot_key(1);
    r.max_key = (heap_size == 0) ? dep_pkg::key_t'(0)
                : slot_key(heap_size < 2 ? heap_size : 2);
    r.entry_count = 11'(heap_size);
    return r;
  endfunction

  task automatic send_request(logic [1:0] op, dep_pkg::key_t k, bit typed = 1'b0,
                              report_t want = '0);
    report_t pred;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= op;
    key_in_i <= k;
    do @(posedge clk_i); while (!in_ready_o);
    pred = apply_request(op, k);
    report_q.push_back(typed ? want : pred);
    requests++;
    if (pred.status == dep_pkg::StFull) full_refusals++;
    if (pred.status == dep_pkg::StEmpty) empty_refusals++;
    @(negedge clk_i);
  endtask

  function automatic dep_pkg::key_t random_key();
    case ($urandom_range(3))
      0: return dep_pkg::key_t'($urandom_range(15)) - dep_pkg::key_t'(8);
      1: return $urandom_range(1) ? dep_pkg::key_t'(32'h7fffffff)
                                  : dep_pkg::key_t'(32'h80000000);
      default: return dep_pkg::key_t'($urandom);
    endcase
  endfunction

  task automatic random_request(int unsigned push_pct);
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < push_pct) send_request(dep_pkg::OpPush, random_key());
    else if (pick < push_pct + (100 - push_pct) / 2 - 1)
      send_request(dep_pkg::OpPopMin, random_key());
    else if (pick < 99) send_request(dep_pkg::OpPopMax, random_key());
    else send_request(OpNone, random_key());
  endtask

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= receiver_idle_pct);
  end

  always @(posedge clk_i) begin
    report_t exp_r;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("double_ended_priority_queue_core: mismatch");
      $finish;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (report_q.size() == 0) begin
        $error("report with no request outstanding");
        errors++;
      end else begin
        exp_r = report_q.pop_front();
        if (min_key_o !== exp_r.min_key) begin
          $error("min_key expected %0d got %0d", exp_r.min_key, min_key_o);
          errors++;
        end
        if (max_key_o !== exp_r.max_key) begin
          $error("max_key expected %0d got %0d", exp_r.max_key, max_key_o);
          errors++;
        end
        if (entry_count_o !== exp_r.entry_count) begin
          $error("entry_count expected %0d got %0d", exp_r.entry_count, entry_count_o);
          errors++;
        end
        if (status_o !== exp_r.status) begin
          $error("status expected %0d got %0d", exp_r.status, status_o);
          errors++;
        end
      end
    end
  end

  row_t directed [$];

  function automatic row_t mk(logic [1:0] op, dep_pkg::key_t k, bit typed = 1'b0,
                              dep_pkg::key_t mn = 0, dep_pkg::key_t mx = 0,
                              int unsigned n = 0, logic [1:0] st = dep_pkg::StDone);
    row_t r;
    r.op = op;
    r.key = k;
    r.typed = typed;
    r.want = '{mn, mx, 11'(n), st};
    return r;
  endfunction

  initial begin
    directed = '{
      mk(dep_pkg::OpPopMin, 0, 1, 0, 0, 0, dep_pkg::StEmpty),
      mk(dep_pkg::OpPopMax, 0, 1, 0, 0, 0, dep_pkg::StEmpty),
      mk(OpNone, 5, 1, 0, 0, 0, dep_pkg::StDone),
      mk(dep_pkg::OpPush, 32'h7fffffff, 1, 32'h7fffffff, 32'h7fffffff, 1, dep_pkg::StDone),
      mk(dep_pkg::OpPush, 32'h80000000, 1, 32'h80000000, 32'h7fffffff, 2, dep_pkg::StDone),
      mk(dep_pkg::OpPush, 0),
      mk(dep_pkg::OpPush, -1),
      mk(dep_pkg::OpPush, 7),
      mk(dep_pkg::OpPush, 7),
      mk(dep_pkg::OpPush, 7),
      mk(OpNone, 3),
      mk(dep_pkg::OpPopMax, 0),
      mk(dep_pkg::OpPopMin, 0),
      mk(dep_pkg::OpPopMax, 0),
      mk(dep_pkg::OpPopMin, 0),
      mk(dep_pkg::OpPopMax, 0),
      mk(dep_pkg::OpPopMin, 0),
      mk(dep_pkg::OpPush, -5),
      mk(dep_pkg::OpPopMin, 0),
      mk(dep_pkg::OpPopMin, 0, 1, 0, 0, 0, dep_pkg::StDone)
    };
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int mode = 0; mode < 3; mode++) begin
      sender_idle_pct = (mode == 0) ? 34 : (mode == 1) ? 78 : 0;
      receiver_idle_pct = (mode == 0) ? 78 : (mode == 1) ? 34 : 0;
      if (mode == 0) begin
        foreach (directed[i])
          send_request(directed[i].op, directed[i].key, directed[i].typed, directed[i].want);
        repeat (100) random_request(50);
      end else if (mode == 1) begin
        while (heap_size < dep_pkg::Capacity) random_request(100);
        repeat (6) send_request(dep_pkg::OpPush, random_key());
        repeat (50) random_request(45);
      end else begin
        repeat (150) random_request(20);
        repeat (3) random_request(0);
      end
    end
    in_valid_i <= 1'b0;
    wait (report_q.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);

    $display("%0d requests, queue filled to %0d and worked down to %0d",
             requests, dep_pkg::Capacity, heap_size);
    $display("%0d full refusals, %0d empty refusals", full_refusals, empty_refusals);
    if (errors == 0) begin
      $display("double_ended_priority_queue_core: match");
    end else begin
      $display("double_ended_priority_queue_core: mismatch");
    end
    $finish;
  end
endmodule
`default_nettype wire

>>> files.f
src/dep_pkg.sv
src/dep_ram.sv
src/double_ended_priority_queue_core.sv
test/tb.sv
